### hw/rtl/fwrl_pkg.sv
`timescale 1ns / 1ps

package fwrl_pkg;

  // Defaults for the top-level parameters
  localparam int TABLE_ENTRIES_DEF    = 64;
  localparam int CLEANUP_INTERVAL_DEF = 300;

  // Field widths
  localparam int KEY_W   = 32;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_INDEX_W = 4;

  // Item modes
  localparam logic [1:0] MODE_REQUEST = 2'd0;
  localparam logic [1:0] MODE_FORGET  = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;
  localparam logic [1:0] MODE_QUERY   = 2'd3;

  // Result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_OVER = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_REQUESTS   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SECONDS = 4'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] MAX_REQUESTS_RST   = 16'd100;
  localparam logic [CFG_W-1:0] WINDOW_SECONDS_RST = 16'd60;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  wstart;
  } entry_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_CLEAR,
    ST_DONE
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic start;     // latch the item, rewind the address counter
    logic issue;     // issue one table read
    logic clear_wr;  // write an empty entry at the address counter
    logic update;    // apply the item to the table, form the result
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic addr_last; // address counter sits on the last entry
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

### hw/rtl/fwrl_ram.sv
`timescale 1ns / 1ps

module fwrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/fwrl_ctrl.sv
`timescale 1ns / 1ps

module fwrl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    mode,
  output logic          in_stall,
  output fwrl_pkg::cmd_t cmd,
  input  fwrl_pkg::sts_t sts
);

  fwrl_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwrl_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fwrl_pkg::ST_INIT: begin
        if (sts.addr_last) state_next = fwrl_pkg::ST_IDLE;
      end
      fwrl_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (mode == fwrl_pkg::MODE_CLEAR) state_next = fwrl_pkg::ST_CLEAR;
          else                              state_next = fwrl_pkg::ST_SCAN;
        end
      end
      fwrl_pkg::ST_SCAN: begin
        if (sts.addr_last) state_next = fwrl_pkg::ST_DRAIN;
      end
      fwrl_pkg::ST_DRAIN:  state_next = fwrl_pkg::ST_UPDATE;
      fwrl_pkg::ST_UPDATE: state_next = fwrl_pkg::ST_DONE;
      fwrl_pkg::ST_CLEAR: begin
        if (sts.addr_last) state_next = fwrl_pkg::ST_DONE;
      end
      fwrl_pkg::ST_DONE: begin
        if (sts.out_free) state_next = fwrl_pkg::ST_IDLE;
      end
      default: state_next = fwrl_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    in_stall     = (state != fwrl_pkg::ST_IDLE);
    cmd.start    = (state == fwrl_pkg::ST_IDLE) && in_valid;
    cmd.issue    = (state == fwrl_pkg::ST_SCAN);
    cmd.clear_wr = (state == fwrl_pkg::ST_INIT) || (state == fwrl_pkg::ST_CLEAR);
    cmd.update   = (state == fwrl_pkg::ST_UPDATE);
    cmd.load_out = (state == fwrl_pkg::ST_DONE) && sts.out_free;
  end

endmodule

### hw/rtl/fwrl_dp.sv
`timescale 1ns / 1ps

module fwrl_dp #(
  parameter int TABLE_ENTRIES    = fwrl_pkg::TABLE_ENTRIES_DEF,
  parameter int CLEANUP_INTERVAL = fwrl_pkg::CLEANUP_INTERVAL_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [1:0]                       mode,
  input  logic [fwrl_pkg::KEY_W-1:0]       client_key,
  input  logic [fwrl_pkg::TIME_W-1:0]      time_now,
  input  logic                             cfg_valid,
  input  logic [fwrl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fwrl_pkg::CFG_W-1:0]       cfg_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic [fwrl_pkg::COUNT_W-1:0]     request_count,
  input  fwrl_pkg::cmd_t                   cmd,
  output fwrl_pkg::sts_t                   sts
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int ENT_W = $bits(fwrl_pkg::entry_t);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [fwrl_pkg::TIME_W-1:0] TIME_W_CLEANUP = fwrl_pkg::TIME_W'(CLEANUP_INTERVAL);

  // Configuration
  logic [fwrl_pkg::CFG_W-1:0] max_requests;
  logic [fwrl_pkg::CFG_W-1:0] window_seconds;

  // Latched item
  logic [1:0]                  item_mode;
  logic [fwrl_pkg::KEY_W-1:0]  item_key;
  logic [fwrl_pkg::TIME_W-1:0] item_now;
  logic                        do_sweep;
  logic [fwrl_pkg::TIME_W-1:0] last_cleanup_time;

  // Scan
  logic [IDX_W-1:0] rd_addr;
  logic             rsp_valid;
  logic [IDX_W-1:0] rsp_idx;

  logic                           hit;
  logic [IDX_W-1:0]               hit_idx;
  logic [fwrl_pkg::COUNT_W-1:0]   hit_count;
  logic [fwrl_pkg::TIME_W-1:0]    hit_wstart;
  logic                           free_found;
  logic [IDX_W-1:0]               free_idx;

  // Result waiting for the output register
  logic [1:0]                   res_status;
  logic [fwrl_pkg::COUNT_W-1:0] res_count;

  // RAM
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;
  fwrl_pkg::entry_t rd_ent;

  // Per-read evaluation
  logic [fwrl_pkg::TIME_W-1:0] rd_age;
  logic                        rd_stale;
  logic                        rd_live;

  // Update decision
  logic                         upd_we;
  logic [IDX_W-1:0]             upd_idx;
  fwrl_pkg::entry_t             upd_ent;
  logic [1:0]                   upd_status;
  logic [fwrl_pkg::COUNT_W-1:0] upd_count;
  logic [fwrl_pkg::TIME_W-1:0]  hit_age;

  fwrl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign rd_ent   = fwrl_pkg::entry_t'(ram_rdata);
  assign rd_age   = item_now - rd_ent.wstart;
  // sweep drops entries whose window began two windows ago or earlier
  assign rd_stale = do_sweep && rd_ent.valid && (rd_age >= {15'd0, window_seconds, 1'b0});
  assign rd_live  = rd_ent.valid && !rd_stale;

  assign hit_age  = item_now - hit_wstart;

  always_comb begin
    upd_we     = 1'b0;
    upd_idx    = hit_idx;
    upd_ent    = '{valid: 1'b1, key: item_key, count: 16'd1, wstart: item_now};
    upd_status = fwrl_pkg::STATUS_OK;
    upd_count  = '0;
    case (item_mode)
      fwrl_pkg::MODE_REQUEST: begin
        if (!hit) begin
          if (free_found) begin
            upd_we    = 1'b1;
            upd_idx   = free_idx;
            upd_count = 16'd1;
          end else begin
            upd_status = fwrl_pkg::STATUS_FULL;
          end
        end else if (hit_age >= {16'd0, window_seconds}) begin
          upd_we    = 1'b1;
          upd_count = 16'd1;
        end else if (hit_count >= max_requests) begin
          upd_status = fwrl_pkg::STATUS_OVER;
          upd_count  = hit_count;
        end else begin
          upd_we         = 1'b1;
          upd_ent.count  = hit_count + 16'd1;
          upd_ent.wstart = hit_wstart;
          upd_count      = hit_count + 16'd1;
        end
      end
      fwrl_pkg::MODE_FORGET: begin
        upd_we        = hit;
        upd_ent.valid = 1'b0;
      end
      fwrl_pkg::MODE_QUERY: begin
        if (hit) upd_count = hit_count;
      end
      default: begin
        upd_we = 1'b0;
      end
    endcase
  end

  // One write port: clearing pass, sweep invalidation, or item update
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_addr;
    ram_wdata = '0;
    if (cmd.clear_wr) begin
      ram_we = 1'b1;
    end else if (rsp_valid && rd_stale) begin
      ram_we    = 1'b1;
      ram_waddr = rsp_idx;
      ram_wdata = {1'b0, ram_rdata[ENT_W-2:0]};
    end else if (cmd.update && upd_we) begin
      ram_we    = 1'b1;
      ram_waddr = upd_idx;
      ram_wdata = ENT_W'(upd_ent);
    end
  end

  assign sts.addr_last = (rd_addr == IDX_LAST);
  assign sts.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_requests      <= fwrl_pkg::MAX_REQUESTS_RST;
      window_seconds    <= fwrl_pkg::WINDOW_SECONDS_RST;
      last_cleanup_time <= '0;
      rd_addr           <= '0;
      rsp_valid         <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == fwrl_pkg::CFG_MAX_REQUESTS)   max_requests   <= cfg_data;
        if (cfg_index == fwrl_pkg::CFG_WINDOW_SECONDS) window_seconds <= cfg_data;
      end

      if (cmd.start) begin
        rd_addr <= '0;
        if (mode == fwrl_pkg::MODE_REQUEST &&
            (time_now - last_cleanup_time) > TIME_W_CLEANUP) begin
          last_cleanup_time <= time_now;
        end
      end else if (cmd.issue || cmd.clear_wr) begin
        rd_addr <= rd_addr + 1'b1;
      end

      rsp_valid <= cmd.issue;

      if (cmd.load_out)   out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rsp_idx <= rd_addr;
    if (cmd.start) begin
      item_mode  <= mode;
      item_key   <= client_key;
      item_now   <= time_now;
      do_sweep   <= (mode == fwrl_pkg::MODE_REQUEST) &&
                    ((time_now - last_cleanup_time) > TIME_W_CLEANUP);
      hit        <= 1'b0;
      free_found <= 1'b0;
      res_status <= fwrl_pkg::STATUS_OK;
      res_count  <= '0;
    end else begin
      if (rsp_valid) begin
        if (rd_live && rd_ent.key == item_key && !hit) begin
          hit        <= 1'b1;
          hit_idx    <= rsp_idx;
          hit_count  <= rd_ent.count;
          hit_wstart <= rd_ent.wstart;
        end
        if (!rd_live && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rsp_idx;
        end
      end
      if (cmd.update) begin
        res_status <= upd_status;
        res_count  <= upd_count;
      end
    end
    if (cmd.load_out) begin
      status        <= res_status;
      request_count <= res_count;
    end
  end

endmodule

### hw/rtl/fixed_window_client_rate_limiter.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in       sink       in_valid / in_stall   mode, client_key, time_now
// out      source     out_valid / out_stall status, request_count
// cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// Request, forget and query items scan the whole table before giving a result:
// the table lives in one RAM and is scanned one entry per cycle
// through its single read port. Clear-all writes every entry before its result.
// After rst a clearing pass over all TABLE_ENTRIES entries runs with in_stall high;
// cfg writes are taken throughout (cfg_ready is always high).
// A finished result sits in the output register, so the next item is
// accepted while out_stall holds the previous one.

module fixed_window_client_rate_limiter #(
  parameter int TABLE_ENTRIES    = fwrl_pkg::TABLE_ENTRIES_DEF,
  parameter int CLEANUP_INTERVAL = fwrl_pkg::CLEANUP_INTERVAL_DEF
) (
  input  logic                             clk,
  input  logic                             rst,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       mode,
  input  logic [fwrl_pkg::KEY_W-1:0]       client_key,
  input  logic [fwrl_pkg::TIME_W-1:0]      time_now,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic [fwrl_pkg::COUNT_W-1:0]     request_count,

  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fwrl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fwrl_pkg::CFG_W-1:0]       cfg_data
);

  fwrl_pkg::cmd_t cmd;
  fwrl_pkg::sts_t sts;

  // registers are plain flops, a write always lands
  assign cfg_ready = 1'b1;

  // Sequencer: reset clearing pass, scan, update, clear-all pass, result hand-off
  fwrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Table RAM, match/free search, fused cleanup sweep, result and cfg registers
  fwrl_dp #(
    .TABLE_ENTRIES    (TABLE_ENTRIES),
    .CLEANUP_INTERVAL (CLEANUP_INTERVAL)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .mode          (mode),
    .client_key    (client_key),
    .time_now      (time_now),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .request_count (request_count),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_CYCLES = 4000;  // cycles with no transfer on any channel
  localparam int IDLE_PCT        = 30;    // idle / stall rate on each side

  // One input item and one result as the checker sees them
  typedef struct packed {
    logic [1:0]                  op;
    logic [fwrl_pkg::KEY_W-1:0]  key;
    logic [fwrl_pkg::TIME_W-1:0] stamp;
  } item_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic [fwrl_pkg::COUNT_W-1:0] count;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        in_valid   = 1'b0;
  logic                        in_stall;
  logic [1:0]                  mode       = fwrl_pkg::MODE_QUERY;
  logic [fwrl_pkg::KEY_W-1:0]  client_key = '0;
  logic [fwrl_pkg::TIME_W-1:0] time_now   = '0;

  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [1:0]                   status;
  logic [fwrl_pkg::COUNT_W-1:0] request_count;

  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [fwrl_pkg::CFG_INDEX_W-1:0] cfg_index = fwrl_pkg::CFG_MAX_REQUESTS;
  logic [fwrl_pkg::CFG_W-1:0]       cfg_data  = '0;

  fixed_window_client_rate_limiter #(
    .TABLE_ENTRIES   (fwrl_pkg::TABLE_ENTRIES_DEF),
    .CLEANUP_INTERVAL(fwrl_pkg::CLEANUP_INTERVAL_DEF)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .client_key   (client_key),
    .time_now     (time_now),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .request_count(request_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow of the limiter: client table, sweep time and both limits
  // ---------------------------------------------------------------------
  logic                         tbl_used  [fwrl_pkg::TABLE_ENTRIES_DEF];
  logic [fwrl_pkg::KEY_W-1:0]   tbl_key   [fwrl_pkg::TABLE_ENTRIES_DEF];
  logic [fwrl_pkg::COUNT_W-1:0] tbl_count [fwrl_pkg::TABLE_ENTRIES_DEF];
  logic [fwrl_pkg::TIME_W-1:0]  tbl_start [fwrl_pkg::TABLE_ENTRIES_DEF];
  logic [fwrl_pkg::TIME_W-1:0]  swept_at = '0;
  logic [fwrl_pkg::CFG_W-1:0]   lim_max  = fwrl_pkg::MAX_REQUESTS_RST;
  logic [fwrl_pkg::CFG_W-1:0]   lim_win  = fwrl_pkg::WINDOW_SECONDS_RST;

  initial begin
    for (int i = 0; i < fwrl_pkg::TABLE_ENTRIES_DEF; i++) tbl_used[i] = 1'b0;
  end

  // What the run went through
  int n_new, n_restart, n_over, n_full, n_sweeps, n_writes;
  int n_in, n_out, mism;

  // Applies one item to the shadow table and returns the result it must give.
  function automatic verdict_t predict_verdict(input item_t it);
    verdict_t                    v;
    int                          slot;
    int                          spare;
    logic [fwrl_pkg::TIME_W-1:0] age;
    logic [fwrl_pkg::TIME_W-1:0] keep_span;
    v.status = fwrl_pkg::STATUS_OK;
    v.count  = '0;
    slot     = -1;
    spare    = -1;
    // Sweep runs only ahead of a request, once the cleanup interval is exceeded;
    // it drops every client whose window began two or more windows ago.
    if (it.op == fwrl_pkg::MODE_REQUEST) begin
      age = it.stamp - swept_at;
      if (age > fwrl_pkg::TIME_W'(fwrl_pkg::CLEANUP_INTERVAL_DEF)) begin
        keep_span = {15'd0, lim_win, 1'b0};
        for (int i = 0; i < fwrl_pkg::TABLE_ENTRIES_DEF; i++) begin
          age = it.stamp - tbl_start[i];
          if (tbl_used[i] && age >= keep_span) tbl_used[i] = 1'b0;
        end
        swept_at = it.stamp;
        n_sweeps++;
      end
    end
    for (int i = 0; i < fwrl_pkg::TABLE_ENTRIES_DEF; i++) begin
      if (slot < 0 && tbl_used[i] && tbl_key[i] == it.key) slot = i;
      if (spare < 0 && !tbl_used[i]) spare = i;
    end
    case (it.op)
      fwrl_pkg::MODE_REQUEST: begin
        if (slot < 0) begin
          if (spare < 0) begin
            // unknown client, no room: table left as it is
            v.status = fwrl_pkg::STATUS_FULL;
            n_full++;
          end else begin
            tbl_used[spare]  = 1'b1;
            tbl_key[spare]   = it.key;
            tbl_count[spare] = 16'd1;
            tbl_start[spare] = it.stamp;
            v.count = 16'd1;
            n_new++;
          end
        end else begin
          age = it.stamp - tbl_start[slot];
          if (age >= {16'd0, lim_win}) begin
            // window over: start a fresh one
            tbl_count[slot] = 16'd1;
            tbl_start[slot] = it.stamp;
            v.count = 16'd1;
            n_restart++;
          end else if (tbl_count[slot] >= lim_max) begin
            v.status = fwrl_pkg::STATUS_OVER;
            v.count  = tbl_count[slot];
            n_over++;
          end else begin
            tbl_count[slot] = tbl_count[slot] + 16'd1;
            v.count = tbl_count[slot];
          end
        end
      end
      fwrl_pkg::MODE_FORGET: begin
        if (slot >= 0) tbl_used[slot] = 1'b0;
      end
      fwrl_pkg::MODE_CLEAR: begin
        for (int i = 0; i < fwrl_pkg::TABLE_ENTRIES_DEF; i++) tbl_used[i] = 1'b0;
      end
      default: begin
        // query leaves table and sweep time alone
        if (slot >= 0) v.count = tbl_count[slot];
      end
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Input driver: pulls pending items, changes pins on the falling edge
  // ---------------------------------------------------------------------
  item_t    item_q[$];     // items waiting to be driven
  verdict_t verdict_q[$];  // results owed by the block, oldest first
  item_t    cur;
  bit       in_busy = 1'b0;  // cur is on the pins and not yet transferred
  bit       calm    = 1'b0;  // no idling or stalling on either side

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_busy) begin
      if (item_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        cur = item_q.pop_front();
        in_busy = 1'b1;
        in_valid   <= 1'b1;
        mode       <= cur.op;
        client_key <= cur.key;
        time_now   <= cur.stamp;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, random per cycle
  always @(negedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // ---------------------------------------------------------------------
  // Monitor: input transfers feed the shadow, output transfers are checked
  // ---------------------------------------------------------------------
  int       quiet_cycles = 0;
  verdict_t want;
  verdict_t got;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        verdict_q.push_back(predict_verdict(cur));
        in_busy = 1'b0;
        n_in++;
      end
      if (out_valid && !out_stall) begin
        n_out++;
        got.status = status;
        got.count  = request_count;
        if (verdict_q.size() == 0) begin
          mism++;
          if (mism <= 10)
            $display("%0t: result with nothing owed: status %0d count %0d",
                     $realtime, got.status, got.count);
        end else begin
          want = verdict_q.pop_front();
          if (got.status !== want.status || got.count !== want.count) begin
            mism++;
            if (mism <= 10)
              $display("%0t: result %0d: status exp %0d got %0d, count exp %0d got %0d",
                       $realtime, n_out, want.status, got.status, want.count, got.count);
          end
        end
      end
    end
    // Watchdog: any transfer on any channel counts as progress
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: watchdog, no transfer for %0d cycles, %0d results owed",
               $realtime, quiet_cycles, verdict_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  logic [fwrl_pkg::TIME_W-1:0] tnow = '0;

  task automatic push_item(input logic [1:0] op, input logic [fwrl_pkg::KEY_W-1:0] key,
                           input logic [fwrl_pkg::TIME_W-1:0] stamp);
    item_t it;
    it.op    = op;
    it.key   = key;
    it.stamp = stamp;
    item_q.push_back(it);
  endtask

  // Block until every queued item is in and every owed result is out.
  task automatic drain();
    while (item_q.size() != 0 || in_busy || verdict_q.size() != 0) @(posedge clk);
  endtask

  // cfg_valid is left high so back-to-back writes never drop it for a step.
  task automatic write_reg(input logic [fwrl_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [fwrl_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == fwrl_pkg::CFG_MAX_REQUESTS) lim_max = val;
    else if (idx == fwrl_pkg::CFG_WINDOW_SECONDS) lim_win = val;
    n_writes++;
  endtask

  // Only called with the block idle (after drain).
  task automatic program_limits(input logic [fwrl_pkg::CFG_W-1:0] max_v,
                                input logic [fwrl_pkg::CFG_W-1:0] win_v);
    write_reg(fwrl_pkg::CFG_MAX_REQUESTS, max_v);
    write_reg(fwrl_pkg::CFG_WINDOW_SECONDS, win_v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly request bursts from a small client pool so limits and windows are hit;
  // the rest is queries, forgets, time jumps that trigger sweeps, and noise.
  // Optionally one table fill that runs past capacity.
  task automatic random_phase(input logic [fwrl_pkg::CFG_W-1:0] max_v,
                              input logic [fwrl_pkg::CFG_W-1:0] win_v,
                              input int n_items, input bit do_fill);
    logic [fwrl_pkg::KEY_W-1:0] pool [6];
    logic [fwrl_pkg::KEY_W-1:0] k;
    logic [fwrl_pkg::KEY_W-1:0] first_k;
    int                         n;
    int                         pick;
    int                         len;
    int                         step_max;
    int                         fill_at;
    bit                         filled;
    program_limits(max_v, win_v);
    for (int i = 0; i < 6; i++) pool[i] = $urandom();
    step_max = (win_v > 40) ? 20 : int'(win_v);
    fill_at  = $urandom_range(0, n_items / 2);
    filled   = 1'b0;
    n        = 0;
    while (n < n_items) begin
      pick = $urandom_range(99);
      if (do_fill && !filled && n >= fill_at) begin
        filled  = 1'b1;
        first_k = $urandom();
        push_item(fwrl_pkg::MODE_CLEAR, $urandom(), tnow);
        for (int j = 0; j < fwrl_pkg::TABLE_ENTRIES_DEF + 4; j++) begin
          tnow += $urandom_range(0, 1);
          push_item(fwrl_pkg::MODE_REQUEST, (j == 0) ? first_k : $urandom(), tnow);
        end
        // known client still served while full; a forget frees a slot for a newcomer
        push_item(fwrl_pkg::MODE_REQUEST, first_k, tnow);
        push_item(fwrl_pkg::MODE_FORGET, first_k, tnow);
        push_item(fwrl_pkg::MODE_REQUEST, $urandom(), tnow);
        n += fwrl_pkg::TABLE_ENTRIES_DEF + 8;
      end else if (pick < 55) begin
        k   = pool[$urandom_range(0, 5)];
        len = $urandom_range(1, 10);
        for (int j = 0; j < len; j++) begin
          tnow += $urandom_range(0, step_max);
          push_item(fwrl_pkg::MODE_REQUEST, k, tnow);
        end
        n += len;
      end else if (pick < 70) begin
        push_item($urandom_range(0, 1) ? fwrl_pkg::MODE_QUERY : fwrl_pkg::MODE_FORGET,
                  pool[$urandom_range(0, 5)], tnow);
        n++;
      end else if (pick < 80) begin
        if ($urandom_range(0, 1)) tnow = $urandom();
        else tnow += $urandom_range(fwrl_pkg::CLEANUP_INTERVAL_DEF - 40,
                                    fwrl_pkg::CLEANUP_INTERVAL_DEF + 100);
        push_item(fwrl_pkg::MODE_REQUEST, pool[$urandom_range(0, 5)], tnow);
        n++;
      end else begin
        push_item(2'($urandom_range(0, 3)), $urandom(),
                  $urandom_range(0, 1) ? $urandom() : tnow);
        n++;
      end
    end
    drain();
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset limits (100 per 60 s): new client, counting, forget of unknown and
    // known clients, window expiry, sweep after a long gap, clear all, time wrap.
    push_item(fwrl_pkg::MODE_QUERY,   32'h0000_0000, 32'd0);
    push_item(fwrl_pkg::MODE_REQUEST, 32'h0000_0000, 32'd0);
    push_item(fwrl_pkg::MODE_REQUEST, 32'h0000_0000, 32'd1);
    push_item(fwrl_pkg::MODE_REQUEST, 32'hFFFF_FFFF, 32'd5);
    push_item(fwrl_pkg::MODE_QUERY,   32'hFFFF_FFFF, 32'd6);
    push_item(fwrl_pkg::MODE_FORGET,  32'h1234_5678, 32'd6);
    push_item(fwrl_pkg::MODE_FORGET,  32'hFFFF_FFFF, 32'd6);
    push_item(fwrl_pkg::MODE_QUERY,   32'hFFFF_FFFF, 32'd7);
    push_item(fwrl_pkg::MODE_REQUEST, 32'h0000_0000, 32'd60);
    push_item(fwrl_pkg::MODE_REQUEST, 32'hA5A5_A5A5, 32'd100);
    push_item(fwrl_pkg::MODE_REQUEST, 32'h5A5A_5A5A, 32'd401);
    push_item(fwrl_pkg::MODE_QUERY,   32'h0000_0000, 32'd401);
    push_item(fwrl_pkg::MODE_CLEAR,   32'h0000_0000, 32'd401);
    push_item(fwrl_pkg::MODE_QUERY,   32'h5A5A_5A5A, 32'd402);
    push_item(fwrl_pkg::MODE_REQUEST, 32'hC0A8_0001, 32'hFFFF_FFF0);
    push_item(fwrl_pkg::MODE_REQUEST, 32'hC0A8_0001, 32'h0000_0010);
    push_item(fwrl_pkg::MODE_QUERY,   32'hC0A8_0001, 32'hFFFF_FFFF);
    drain();

    // One request per very long window: second and third are over the limit
    program_limits(16'd1, 16'hFFFF);
    push_item(fwrl_pkg::MODE_REQUEST, 32'h0A00_0001, 32'h20);
    push_item(fwrl_pkg::MODE_REQUEST, 32'h0A00_0001, 32'h21);
    push_item(fwrl_pkg::MODE_REQUEST, 32'h0A00_0001, 32'h30);
    push_item(fwrl_pkg::MODE_QUERY,   32'h0A00_0001, 32'h30);
    drain();

    // Highest limit, one-second window: restart vs. increment within a second
    program_limits(16'hFFFF, 16'd1);
    push_item(fwrl_pkg::MODE_REQUEST, 32'h0A00_0001, 32'h31);
    push_item(fwrl_pkg::MODE_REQUEST, 32'h0A00_0001, 32'h31);
    push_item(fwrl_pkg::MODE_REQUEST, 32'h0A00_0001, 32'h32);
    drain();
    tnow = 32'h40;

    random_phase(fwrl_pkg::MAX_REQUESTS_RST, fwrl_pkg::WINDOW_SECONDS_RST, 125, 1'b1);
    random_phase(16'd1, 16'd1, 110, 1'b1);
    random_phase(16'hFFFF, 16'hFFFF, 110, 1'b1);
    calm = 1'b1;
    random_phase(16'd3, 16'd10, 125, 1'b0);
    calm = 1'b0;
    random_phase(16'hFFFF, 16'd1, 100, 1'b0);
    random_phase(16'd1, 16'hFFFF, 110, 1'b0);
    random_phase(fwrl_pkg::CFG_W'($urandom_range(1, 65535)),
                 fwrl_pkg::CFG_W'($urandom_range(1, 65535)), 120, 1'b0);
    random_phase(fwrl_pkg::CFG_W'($urandom_range(2, 8)),
                 fwrl_pkg::CFG_W'($urandom_range(5, 200)), 125, 1'b0);

    // Let any stray result surface
    repeat (fwrl_pkg::TABLE_ENTRIES_DEF + 8) @(posedge clk);

    mism += verdict_q.size();
    $display("covered %0d items and %0d results over %0d register writes",
             n_in, n_out, n_writes);
    $display("new clients %0d, window restarts %0d, over limit %0d, table full %0d, sweeps %0d",
             n_new, n_restart, n_over, n_full, n_sweeps);
    if (mism == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
hw/rtl/fwrl_pkg.sv
hw/rtl/fwrl_ram.sv
hw/rtl/fwrl_ctrl.sv
hw/rtl/fwrl_dp.sv
hw/rtl/fixed_window_client_rate_limiter.sv
tb/tb_top.sv
